>>> sv/cmdf_pkg.sv
package cmdf_pkg;

  // default limits handed to the top level parameters
  localparam int MAX_WINDOW_DEF = 16;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // value of rows outside the image and of rows skipped by stride
  localparam logic [15:0] PAD_VALUE = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_ROWS  = 2'd0;
  localparam logic [1:0] REG_ROW_STRIDE   = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FETCH,
    ST_LOAD,
    ST_EMIT,
    ST_WRITE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic setup;
    logic div_step;
    logic fetch_start;
    logic fetch_step;
    logic load_pad;
    logic load_median;
    logic next_row;
    logic write;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic div_done;
    logic rem_zero;
    logic fetch_done;
    logic at_last;
  } status_t;

endpackage

>>> sv/cmdf_ctrl.sv
module cmdf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  cmdf_pkg::status_t  status,
  output cmdf_pkg::cmd_t     cmd
);

  cmdf_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      cmdf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = cmdf_pkg::ST_SETUP;
        end
      end
      cmdf_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        if (status.empty) begin
          state_next = cmdf_pkg::ST_WRITE;
        end else begin
          state_next = cmdf_pkg::ST_DIV;
        end
      end
      cmdf_pkg::ST_DIV: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (status.rem_zero) begin
          cmd.fetch_start = 1'b1;
          state_next      = cmdf_pkg::ST_FETCH;
        end else begin
          cmd.load_pad = 1'b1;
          state_next   = cmdf_pkg::ST_EMIT;
        end
      end
      cmdf_pkg::ST_FETCH: begin
        cmd.fetch_step = 1'b1;
        if (status.fetch_done) begin
          state_next = cmdf_pkg::ST_LOAD;
        end
      end
      cmdf_pkg::ST_LOAD: begin
        cmd.load_median = 1'b1;
        state_next      = cmdf_pkg::ST_EMIT;
      end
      cmdf_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (status.at_last) begin
            state_next = cmdf_pkg::ST_WRITE;
          end else begin
            cmd.next_row = 1'b1;
            state_next   = cmdf_pkg::ST_DIV;
          end
        end
      end
      cmdf_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = cmdf_pkg::ST_IDLE;
      end
      default: begin
        state_next = cmdf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/cmdf_datapath.sv
module cmdf_datapath #(
  parameter int MAX_WINDOW = cmdf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = cmdf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cmdf_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmdf_pkg::cmd_t     cmd,
  output cmdf_pkg::status_t  status,
  input  logic [4:0]         window_rows,
  input  logic [4:0]         row_stride,
  input  logic [10:0]        image_width,
  input  logic [10:0]        image_height,
  input  logic [15:0]        depth_pixel,
  output logic [15:0]        median_depth,
  output logic [9:0]         out_row,
  output logic [9:0]         out_col,
  output logic               last_of_run
);

  localparam int STORE_ROWS = MAX_WINDOW - 1;
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int CWW        = $clog2(MAX_WIDTH + 1);
  localparam int RB         = $clog2(MAX_HEIGHT);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int SR         = RB + 2;
  localparam int SW         = $clog2(STORE_ROWS);
  localparam int SLW        = $clog2(2 * STORE_ROWS);
  localparam int WW         = $clog2(MAX_WINDOW + 1);
  localparam int IW         = $clog2(MAX_WINDOW);
  localparam int DCW        = $clog2(RB + 1);

  // clamped settings
  logic [WW-1:0]  w;
  logic [4:0]     s;
  logic [CWW-1:0] wd;
  logic [HW-1:0]  h;

  always_comb begin
    if (window_rows < 5'd3) begin
      w = WW'(3);
    end else if (32'(window_rows) > MAX_WINDOW) begin
      w = WW'(MAX_WINDOW);
    end else begin
      w = WW'(window_rows);
    end
    s = (row_stride == 5'd0) ? 5'd1 : row_stride;
    if (image_width == 11'd0) begin
      wd = CWW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      wd = CWW'(MAX_WIDTH);
    end else begin
      wd = CWW'(image_width);
    end
    if (image_height == 11'd0) begin
      h = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(image_height);
    end
  end

  // stream position, line store and item registers
  logic [CWW-1:0] col_count;
  logic [RB-1:0]  row_count;
  logic [SW-1:0]  slot_count;
  logic [15:0]    pixel;
  logic [RB-1:0]  cur;
  logic [CW-1:0]  c;
  logic [SW-1:0]  cur_slot;
  logic [RB-1:0]  r_reg;
  logic [RB-1:0]  last_reg;
  logic [15:0]    median_reg;
  logic [15:0]    line_mem [DEPTH];
  logic [15:0]    mem_q;

  // position of the arriving word, wrapped to the current size
  logic           row_inc;
  logic [HW-1:0]  row_a;
  logic [SW-1:0]  slot_a;
  logic [RB-1:0]  row_w;
  logic [SW-1:0]  slot_w;
  logic [CW-1:0]  col_w;

  always_comb begin
    row_inc = (col_count >= wd);
    row_a   = HW'(row_count) + HW'(row_inc);
    slot_a  = slot_count;
    if (row_inc) begin
      slot_a = (32'(slot_count) == STORE_ROWS - 1) ? '0 : slot_count + SW'(1);
    end
    col_w  = row_inc ? '0 : CW'(col_count);
    row_w  = RB'(row_a);
    slot_w = slot_a;
    if (row_a >= h) begin
      row_w  = '0;
      slot_w = '0;
    end
  end

  // position after the word, wrapped to the size it was taken with
  logic [CWW-1:0] col_next;
  logic [RB-1:0]  row_next;
  logic [SW-1:0]  slot_next;

  always_comb begin
    col_next  = CWW'(c) + CWW'(1);
    row_next  = cur;
    slot_next = cur_slot;
    if (col_next >= wd) begin
      col_next = '0;
      if (HW'(cur) + HW'(1) >= h) begin
        row_next  = '0;
        slot_next = '0;
      end else begin
        row_next  = cur + RB'(1);
        slot_next = (32'(cur_slot) == STORE_ROWS - 1) ? '0 : cur_slot + SW'(1);
      end
    end
  end

  // span of centre rows for this word
  logic signed [SR-1:0] below;
  logic signed [SR-1:0] first_s;
  logic signed [SR-1:0] last_s;
  logic signed [SR-1:0] start_s;

  always_comb begin
    below   = SR'(w - WW'(1) - (w >> 1));
    first_s = $signed(SR'(cur)) - below;
    last_s  = (HW'(cur) == h - HW'(1)) ? $signed(SR'(cur)) : first_s;
    start_s = (first_s < 0) ? '0 : first_s;
  end

  // row modulo stride, one bit a cycle
  logic [RB-1:0]  dividend;
  logic [4:0]     rem;
  logic [DCW-1:0] div_cnt;
  logic [5:0]     rem_sh;
  logic [RB-1:0]  r_plus;

  assign rem_sh = {rem, dividend[RB-1]};
  assign r_plus = r_reg + RB'(1);

  // window row fetch
  logic [WW-1:0]        k;
  logic                 vld_d;
  logic                 pad_d;
  logic                 cur_d;
  logic signed [SR-1:0] q;
  logic signed [SR-1:0] d;
  logic                 pad;
  logic [SLW-1:0]       slot_sum;
  logic [SLW-1:0]       slot_q;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  always_comb begin
    q        = $signed(SR'(r_reg)) - $signed(SR'(w >> 1)) + $signed(SR'(k));
    pad      = (q < 0) || (q >= $signed(SR'(h)));
    d        = $signed(SR'(cur)) - q;
    slot_sum = SLW'(cur_slot) + SLW'(STORE_ROWS) - SLW'(d);
    slot_q   = (32'(slot_sum) >= STORE_ROWS) ? slot_sum - SLW'(STORE_ROWS) : slot_sum;
    rd_addr  = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(c);
    wr_addr  = AW'(cur_slot) * AW'(MAX_WIDTH) + AW'(c);
  end

  // insertion sorter
  logic [15:0]   sorted      [MAX_WINDOW];
  logic [15:0]   sorted_next [MAX_WINDOW];
  logic [WW-1:0] n;
  logic [15:0]   v;
  logic          gt [MAX_WINDOW];
  logic [IW-1:0] mid;

  always_comb begin
    v = pad_d ? cmdf_pkg::PAD_VALUE : (cur_d ? pixel : mem_q);
    for (int i = 0; i < MAX_WINDOW; i++) begin
      gt[i] = (WW'(i) >= n) || (sorted[i] > v);
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (!gt[i]) begin
        sorted_next[i] = sorted[i];
      end else if (i == 0) begin
        sorted_next[i] = v;
      end else if (!gt[i-1]) begin
        sorted_next[i] = v;
      end else begin
        sorted_next[i] = sorted[i-1];
      end
    end
    mid = IW'(w >> 1) + IW'(1);
  end

  // line store
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      line_mem[wr_addr] <= pixel;
    end
    mem_q <= line_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      slot_count <= '0;
      vld_d      <= 1'b0;
    end else begin
      if (cmd.write) begin
        col_count  <= col_next;
        row_count  <= row_next;
        slot_count <= slot_next;
      end
      vld_d <= cmd.fetch_step && (k < w);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pixel    <= depth_pixel;
      cur      <= row_w;
      c        <= col_w;
      cur_slot <= slot_w;
    end
    if (cmd.setup) begin
      r_reg    <= RB'(start_s);
      last_reg <= RB'(last_s);
      dividend <= RB'(start_s);
      rem      <= '0;
      div_cnt  <= DCW'(RB);
    end
    if (cmd.next_row) begin
      r_reg    <= r_plus;
      dividend <= r_plus;
      rem      <= '0;
      div_cnt  <= DCW'(RB);
    end
    if (cmd.div_step) begin
      rem      <= (rem_sh >= {1'b0, s}) ? 5'(rem_sh - {1'b0, s}) : rem_sh[4:0];
      dividend <= dividend << 1;
      div_cnt  <= div_cnt - DCW'(1);
    end
    if (cmd.fetch_start) begin
      k <= '0;
      n <= '0;
    end
    if (cmd.fetch_step) begin
      k     <= k + WW'(1);
      pad_d <= pad;
      cur_d <= (q == $signed(SR'(cur)));
    end
    if (vld_d) begin
      sorted <= sorted_next;
      n      <= n + WW'(1);
    end
    if (cmd.load_pad) begin
      median_reg <= cmdf_pkg::PAD_VALUE;
    end
    if (cmd.load_median) begin
      median_reg <= sorted[mid];
    end
  end

  // status back to the controller
  always_comb begin
    status.empty      = (last_s < start_s);
    status.div_done   = (div_cnt == '0);
    status.rem_zero   = (rem == '0);
    status.fetch_done = (k == w);
    status.at_last    = (r_reg == last_reg);
  end

  // result word
  logic [31:0] r32;
  logic [31:0] c32;

  assign r32          = 32'(r_reg);
  assign c32          = 32'(c);
  assign median_depth = median_reg;
  assign out_row      = r32[9:0];
  assign out_col      = c32[9:0];
  assign last_of_run  = status.at_last;

endmodule

>>> sv/column_median_depth_filter_core.sv
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  depth_pixel
// result    out        out_valid/out_stall  median_depth, out_row, out_col, last_of_run
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word at a time: a word that yields no result is taken, set up and written;
// each result adds a row-modulo-stride iteration, then on rows that get a median
// reads of the clamped window of rows from the line store and sorting, then the
// result word is shown; the single line store read port makes the reads sequential.
// rst is synchronous; the line store is not cleared and needs no sweep.
// a stalled result holds the block; no new word is taken until it is gone.
module column_median_depth_filter_core #(
  parameter int MAX_WINDOW = cmdf_pkg::MAX_WINDOW_DEF,
  parameter int MAX_WIDTH  = cmdf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cmdf_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] depth_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] median_depth,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [4:0]  window_rows;
  logic [4:0]  row_stride;
  logic [10:0] image_width;
  logic [10:0] image_height;

  cmdf_pkg::cmd_t    cmd;
  cmdf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_rows  <= 5'd10;
      row_stride   <= 5'd1;
      image_width  <= 11'd640;
      image_height <= 11'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cmdf_pkg::REG_WINDOW_ROWS:  window_rows  <= cfg_data[4:0];
        cmdf_pkg::REG_ROW_STRIDE:   row_stride   <= cfg_data[4:0];
        cmdf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        cmdf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  cmdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cmdf_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .window_rows  (window_rows),
    .row_stride   (row_stride),
    .image_width  (image_width),
    .image_height (image_height),
    .depth_pixel  (depth_pixel),
    .median_depth (median_depth),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_run  (last_of_run)
  );

endmodule
